// ----- src/hpor_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpor_pkg
// Shared beat types and codes of the handle pool with oldest-first reuse.
// ----------------------------------------------------------------------------
package hpor_pkg;

    localparam logic ACT_GET     = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [2:0] STS_FREE     = 3'd0;
    localparam logic [2:0] STS_RECLAIM  = 3'd1;
    localparam logic [2:0] STS_RELEASED = 3'd2;
    localparam logic [2:0] STS_IGNORED  = 3'd3;
    localparam logic [2:0] STS_EMPTY    = 3'd4;

    typedef struct packed {
        logic       action;
        logic [3:0] handle;
        logic       handle_invalid;
    } t_cmd;

    typedef struct packed {
        logic [3:0] granted_handle;
        logic [2:0] status;
        logic [4:0] free_count;
    } t_res;

endpackage

// ----- src/hpor_free_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpor_free_queue
// Circular free-handle store. Writes go to the tail in order; an entry not
// yet written reads back as its own index, which is its reset content.
// ----------------------------------------------------------------------------
module hpor_free_queue
    import hpor_pkg::*;
#(
    parameter int POOL_SIZE = 16,
    parameter int HW        = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [HW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [HW-1:0] i_wr_data,
    output logic [HW-1:0] o_rd_data
);

    logic [HW-1:0] r_mem [POOL_SIZE];
    logic [HW-1:0] r_tail;
    logic          r_all;
    logic [HW-1:0] r_q;
    logic [HW-1:0] r_addr;
    logic          r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= '0;
            r_all  <= 1'b0;
        end else if (i_wr_en) begin
            if (r_tail == HW'(POOL_SIZE - 1)) begin
                r_tail <= '0;
                r_all  <= 1'b1;
            end else begin
                r_tail <= r_tail + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_tail] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q    <= r_mem[i_rd_addr];
            r_addr <= i_rd_addr;
            r_hit  <= r_all || (i_rd_addr < r_tail);
        end
    end

    assign o_rd_data = r_hit ? r_q : r_addr;

endmodule

// ----- src/hpor_link_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpor_link_table
// Per-handle word of the in-use list: in-use flag, next and prev links.
// Handles never granted read with the flag cleared.
// ----------------------------------------------------------------------------
module hpor_link_table
    import hpor_pkg::*;
#(
    parameter int POOL_SIZE = 16,
    parameter int HW        = 4
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [HW-1:0] i_rd_addr,
    input  logic [HW-1:0] i_fill,
    input  logic          i_fill_all,
    input  logic          i_wr_en,
    input  logic [HW-1:0] i_wr_addr,
    input  logic          i_wr_flag,
    input  logic [HW-1:0] i_wr_next,
    input  logic [HW-1:0] i_wr_prev,
    output logic          o_flag,
    output logic [HW-1:0] o_next,
    output logic [HW-1:0] o_prev
);

    localparam int LW = 2 * HW + 1;

    logic [LW-1:0] r_mem [POOL_SIZE];
    logic [LW-1:0] r_q;
    logic          r_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_flag, i_wr_next, i_wr_prev};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q   <= r_mem[i_rd_addr];
            r_hit <= i_fill_all || (i_rd_addr < i_fill);
        end
    end

    assign o_flag = r_hit & r_q[LW-1];
    assign o_next = r_q[LW-2:HW];
    assign o_prev = r_q[HW-1:0];

endmodule

// ----- src/handle_pool_oldest_reuse_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_oldest_reuse_unit
// Handle pool: free FIFO plus an in-use list ordered by grant age, with the
// oldest in-use handle reclaimed when the FIFO runs dry.
//
//   channel   direction  ports                  handshake
//   command   in         i_cmd (t_cmd)          start high, busy low
//   result    out        o_res (t_res)          o_strobe, one cycle
//
// An invalid or out-of-pool release, a pool-empty get and a reclaim of the
// only in-use handle answer from idle. A get reads the free FIFO and, if the
// list is not empty, the newest entry; a reclaim reads the oldest, then the
// newest entry; a release reads the flag and, from mid-list, relinks the
// previous then the next neighbour. Each step does at most one read and one
// write of the link table. Reset clears all control state at once; no
// clearing pass. busy drops with the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module handle_pool_oldest_reuse_unit
    import hpor_pkg::*;
#(
    parameter int POOL_SIZE = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    localparam int HW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int FW = $clog2(POOL_SIZE + 1);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_GET_FQ  = 7'b0000010,
        ST_APP_RD  = 7'b0000100,
        ST_RCL_RD  = 7'b0001000,
        ST_REL_CHK = 7'b0010000,
        ST_MID_PV  = 7'b0100000,
        ST_MID_NX  = 7'b1000000
    } t_state;

    t_state        r_state,    n_state;
    logic [HW-1:0] r_head,     n_head;
    logic          r_head_all, n_head_all;
    logic [FW-1:0] r_free,     n_free;
    logic [FW-1:0] r_use,      n_use;
    logic [HW-1:0] r_oldest,   n_oldest;
    logic [HW-1:0] r_newest,   n_newest;
    logic          r_reclaim,  n_reclaim;
    logic [HW-1:0] r_h,        n_h;
    logic [HW-1:0] r_g,        n_g;
    logic [HW-1:0] r_nx,       n_nx;
    logic [HW-1:0] r_pv,       n_pv;
    logic          r_strobe,   n_strobe;
    t_res          r_res,      n_res;

    logic          fq_rd_en;
    logic          fq_wr_en;
    logic [HW-1:0] fq_q;
    logic          lk_rd_en;
    logic [HW-1:0] lk_rd_addr;
    logic          lk_wr_en;
    logic [HW-1:0] lk_wr_addr;
    logic          lk_wr_flag;
    logic [HW-1:0] lk_wr_next;
    logic [HW-1:0] lk_wr_prev;
    logic          lk_flag;
    logic [HW-1:0] lk_next;
    logic [HW-1:0] lk_prev;

    logic          fin;
    logic [HW-1:0] fin_g;
    logic [2:0]    fin_st;

    hpor_free_queue #(
        .POOL_SIZE(POOL_SIZE),
        .HW       (HW)
    ) u_fq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (fq_rd_en),
        .i_rd_addr(r_head),
        .i_wr_en  (fq_wr_en),
        .i_wr_data(r_h),
        .o_rd_data(fq_q)
    );

    hpor_link_table #(
        .POOL_SIZE(POOL_SIZE),
        .HW       (HW)
    ) u_lk (
        .i_clk     (i_clk),
        .i_rd_en   (lk_rd_en),
        .i_rd_addr (lk_rd_addr),
        .i_fill    (r_head),
        .i_fill_all(r_head_all),
        .i_wr_en   (lk_wr_en),
        .i_wr_addr (lk_wr_addr),
        .i_wr_flag (lk_wr_flag),
        .i_wr_next (lk_wr_next),
        .i_wr_prev (lk_wr_prev),
        .o_flag    (lk_flag),
        .o_next    (lk_next),
        .o_prev    (lk_prev)
    );

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_head_all = r_head_all;
        n_free     = r_free;
        n_use      = r_use;
        n_oldest   = r_oldest;
        n_newest   = r_newest;
        n_reclaim  = r_reclaim;
        n_h        = r_h;
        n_g        = r_g;
        n_nx       = r_nx;
        n_pv       = r_pv;
        n_strobe   = 1'b0;
        n_res      = r_res;
        fq_rd_en   = 1'b0;
        fq_wr_en   = 1'b0;
        lk_rd_en   = 1'b0;
        lk_rd_addr = r_newest;
        lk_wr_en   = 1'b0;
        lk_wr_addr = r_g;
        lk_wr_flag = 1'b1;
        lk_wr_next = r_g;
        lk_wr_prev = r_newest;
        fin        = 1'b0;
        fin_g      = '0;
        fin_st     = STS_IGNORED;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_h = HW'(i_cmd.handle);
                    if (i_cmd.action == ACT_GET) begin
                        if (r_free != '0) begin
                            fq_rd_en  = 1'b1;
                            n_reclaim = 1'b0;
                            n_state   = ST_GET_FQ;
                        end else if (r_use != '0) begin
                            n_g = r_oldest;
                            if (r_use > FW'(1)) begin
                                lk_rd_en   = 1'b1;
                                lk_rd_addr = r_oldest;
                                n_reclaim  = 1'b1;
                                n_state    = ST_RCL_RD;
                            end else begin
                                fin    = 1'b1;
                                fin_g  = r_oldest;
                                fin_st = STS_RECLAIM;
                            end
                        end else begin
                            fin    = 1'b1;
                            fin_st = STS_EMPTY;
                        end
                    end else begin
                        if (i_cmd.handle_invalid || (32'(i_cmd.handle) >= POOL_SIZE)) begin
                            fin    = 1'b1;
                            fin_st = STS_IGNORED;
                        end else begin
                            lk_rd_en   = 1'b1;
                            lk_rd_addr = HW'(i_cmd.handle);
                            n_state    = ST_REL_CHK;
                        end
                    end
                end
            end
            ST_GET_FQ: begin
                n_g = fq_q;
                if (r_head == HW'(POOL_SIZE - 1)) begin
                    n_head     = '0;
                    n_head_all = 1'b1;
                end else begin
                    n_head = r_head + 1'b1;
                end
                n_free     = r_free - 1'b1;
                lk_wr_en   = 1'b1;
                lk_wr_addr = fq_q;
                lk_wr_next = fq_q;
                if (r_use == '0) begin
                    n_oldest = fq_q;
                    n_newest = fq_q;
                    n_use    = r_use + 1'b1;
                    fin      = 1'b1;
                    fin_g    = fq_q;
                    fin_st   = STS_FREE;
                    n_state  = ST_IDLE;
                end else begin
                    lk_rd_en   = 1'b1;
                    lk_rd_addr = r_newest;
                    n_state    = ST_APP_RD;
                end
            end
            ST_RCL_RD: begin
                n_oldest   = lk_next;
                lk_wr_en   = 1'b1;
                lk_rd_en   = 1'b1;
                lk_rd_addr = r_newest;
                n_state    = ST_APP_RD;
            end
            ST_APP_RD: begin
                lk_wr_en   = 1'b1;
                lk_wr_addr = r_newest;
                lk_wr_flag = lk_flag;
                lk_wr_next = r_g;
                lk_wr_prev = lk_prev;
                n_newest   = r_g;
                if (!r_reclaim) begin
                    n_use = r_use + 1'b1;
                end
                fin     = 1'b1;
                fin_g   = r_g;
                fin_st  = r_reclaim ? STS_RECLAIM : STS_FREE;
                n_state = ST_IDLE;
            end
            ST_REL_CHK: begin
                if (!lk_flag || (32'(r_free) >= POOL_SIZE)) begin
                    fin     = 1'b1;
                    fin_st  = STS_IGNORED;
                    n_state = ST_IDLE;
                end else begin
                    lk_wr_en   = 1'b1;
                    lk_wr_addr = r_h;
                    lk_wr_flag = 1'b0;
                    lk_wr_next = lk_next;
                    lk_wr_prev = lk_prev;
                    fq_wr_en   = 1'b1;
                    n_free     = r_free + 1'b1;
                    n_use      = r_use - 1'b1;
                    priority if (r_use <= FW'(1)) begin
                        n_oldest = '0;
                        n_newest = '0;
                        fin      = 1'b1;
                        n_state  = ST_IDLE;
                    end else if (r_h == r_oldest) begin
                        n_oldest = lk_next;
                        fin      = 1'b1;
                        n_state  = ST_IDLE;
                    end else if (r_h == r_newest) begin
                        n_newest = lk_prev;
                        fin      = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_nx       = lk_next;
                        n_pv       = lk_prev;
                        lk_rd_en   = 1'b1;
                        lk_rd_addr = lk_prev;
                        n_state    = ST_MID_PV;
                    end
                    fin_st = STS_RELEASED;
                end
            end
            ST_MID_PV: begin
                lk_wr_en   = 1'b1;
                lk_wr_addr = r_pv;
                lk_wr_flag = lk_flag;
                lk_wr_next = r_nx;
                lk_wr_prev = lk_prev;
                lk_rd_en   = 1'b1;
                lk_rd_addr = r_nx;
                n_state    = ST_MID_NX;
            end
            ST_MID_NX: begin
                lk_wr_en   = 1'b1;
                lk_wr_addr = r_nx;
                lk_wr_flag = lk_flag;
                lk_wr_next = lk_next;
                lk_wr_prev = r_pv;
                fin        = 1'b1;
                fin_st     = STS_RELEASED;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (fin) begin
            n_strobe             = 1'b1;
            n_res.granted_handle = 4'(fin_g);
            n_res.status         = fin_st;
            n_res.free_count     = 5'(n_free);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_head_all <= 1'b0;
            r_free     <= FW'(POOL_SIZE);
            r_use      <= '0;
            r_oldest   <= '0;
            r_newest   <= '0;
            r_reclaim  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_head_all <= n_head_all;
            r_free     <= n_free;
            r_use      <= n_use;
            r_oldest   <= n_oldest;
            r_newest   <= n_newest;
            r_reclaim  <= n_reclaim;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h   <= n_h;
        r_g   <= n_g;
        r_nx  <= n_nx;
        r_pv  <= n_pv;
        r_res <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef SYNTHESIS
    a_pool_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((32'(r_free) + 32'(r_use)) == POOL_SIZE))
        else $error("free and in-use counts do not add up to the pool size");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_state == ST_IDLE))
        else $error("result beat while a step is still in progress");

    a_reclaim_dry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_res.status == STS_RECLAIM)) |-> (r_free == '0))
        else $error("reclaim while free handles remain");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted beat neither in progress nor answered");
`endif

endmodule

// ----- tb/handle_pool_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_tracker
// Watches the command and result channels of the handle pool, keeps its own
// free FIFO and grant-age list, and checks every result beat field by field
// against the answer it worked out when the command was accepted.
// ----------------------------------------------------------------------------
module handle_pool_tracker
    import hpor_pkg::*;
#(
    parameter int POOL_SIZE = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_cmd i_cmd,
    input  logic i_strobe,
    input  t_res i_res,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_fresh,
    output int   o_reclaim,
    output int   o_freed,
    output int   o_ignored
);

    logic [3:0]  free_fifo [POOL_SIZE];
    logic [3:0]  fifo_head;
    int unsigned fifo_count;
    logic [3:0]  link_next [POOL_SIZE];
    logic [3:0]  link_prev [POOL_SIZE];
    logic [3:0]  age_oldest;
    logic [3:0]  age_newest;
    int unsigned age_count;
    bit          held [POOL_SIZE];

    t_res answers_due [$];
    int   mismatch_count = 0;
    int   beats_seen = 0;
    int   fresh_count = 0;
    int   reclaim_count = 0;
    int   freed_count = 0;
    int   ignored_count = 0;
    int   due_count = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = due_count;
    assign o_fresh       = fresh_count;
    assign o_reclaim     = reclaim_count;
    assign o_freed       = freed_count;
    assign o_ignored     = ignored_count;

    task automatic note_mismatch(input string what);
        $display("%0t ns  mismatch at result beat %0d: %s", $realtime, beats_seen, what);
        mismatch_count++;
    endtask

    task automatic restock_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            free_fifo[i] = 4'(i);
            link_next[i] = 4'd0;
            link_prev[i] = 4'd0;
            held[i]      = 1'b0;
        end
        fifo_head  = 4'd0;
        fifo_count = POOL_SIZE;
        age_oldest = 4'd0;
        age_newest = 4'd0;
        age_count  = 0;
    endtask

    task automatic age_append(input logic [3:0] h);
        if (age_count == 0) begin
            age_oldest = h;
        end else begin
            link_next[age_newest] = h;
            link_prev[h]          = age_newest;
        end
        age_newest = h;
        age_count++;
        held[h] = 1'b1;
    endtask

    task automatic age_unlink(input logic [3:0] h);
        if (age_count <= 1) begin
            age_oldest = 4'd0;
            age_newest = 4'd0;
        end else if (h == age_oldest) begin
            age_oldest = link_next[h];
        end else if (h == age_newest) begin
            age_newest = link_prev[h];
        end else begin
            link_next[link_prev[h]] = link_next[h];
            link_prev[link_next[h]] = link_prev[h];
        end
        if (age_count > 0) age_count--;
        held[h] = 1'b0;
    endtask

    task automatic foresee_answer(input t_cmd c, output t_res r);
        logic [3:0] granted;
        logic [2:0] code;
        granted = 4'd0;
        if (c.action == ACT_GET) begin
            if (fifo_count > 0) begin
                granted   = free_fifo[fifo_head];
                fifo_head = fifo_head + 4'd1;
                fifo_count--;
                age_append(granted);
                code = STS_FREE;
            end else if (age_count > 0) begin
                granted = age_oldest;
                if (age_count > 1) begin
                    age_unlink(granted);
                    age_append(granted);
                end
                code = STS_RECLAIM;
            end else begin
                code = STS_EMPTY;
            end
        end else if (c.handle_invalid || int'(c.handle) >= POOL_SIZE || !held[c.handle] ||
                     fifo_count >= POOL_SIZE) begin
            code = STS_IGNORED;
        end else begin
            age_unlink(c.handle);
            free_fifo[fifo_head + 4'(fifo_count)] = c.handle;
            fifo_count++;
            code = STS_RELEASED;
        end
        r.granted_handle = granted;
        r.status         = code;
        r.free_count     = 5'(fifo_count);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            restock_pool();
            answers_due.delete();
        end else begin
            if (i_strobe) begin
                beats_seen++;
                if (answers_due.size() == 0) begin
                    note_mismatch($sformatf("stray result handle %0d status %0d free %0d",
                                            i_res.granted_handle, i_res.status,
                                            i_res.free_count));
                end else begin
                    want = answers_due.pop_front();
                    if (i_res.granted_handle !== want.granted_handle)
                        note_mismatch($sformatf("granted_handle %0d, want %0d",
                                                i_res.granted_handle, want.granted_handle));
                    if (i_res.status !== want.status)
                        note_mismatch($sformatf("status %0d, want %0d",
                                                i_res.status, want.status));
                    if (i_res.free_count !== want.free_count)
                        note_mismatch($sformatf("free_count %0d, want %0d",
                                                i_res.free_count, want.free_count));
                end
            end
            if (i_start && !i_busy) begin
                foresee_answer(i_cmd, want);
                answers_due = {answers_due, want};
                case (want.status)
                    STS_FREE:     fresh_count++;
                    STS_RECLAIM:  reclaim_count++;
                    STS_RELEASED: freed_count++;
                    default:      ignored_count++;
                endcase
            end
        end
        due_count <= answers_due.size();
    end

endmodule

// ----- tb/tb_handle_pool_oldest_reuse_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handle_pool_oldest_reuse_unit
// Drives get and release commands into the handle pool: a directed opening
// that drains the pool, reclaims, and frees from both ends and the middle,
// then random traffic whose get/release mix swings so the free count sweeps
// its full range, under heavy, light and no command idling.
// ----------------------------------------------------------------------------
module tb_handle_pool_oldest_reuse_unit;
    import hpor_pkg::*;

    localparam int POOL_SIZE    = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 560;
    localparam int CHUNK_ITEMS  = 50;
    localparam int SETTLE_TICKS = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_cmd i_cmd;
    logic busy;
    logic o_strobe;
    t_res o_res;

    int mismatches;
    int outstanding;
    int n_fresh;
    int n_reclaim;
    int n_freed;
    int n_ignored;
    int cycles = 0;
    int sent = 0;
    int idle_pct = 0;

    handle_pool_oldest_reuse_unit #(
        .POOL_SIZE(POOL_SIZE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    handle_pool_tracker #(
        .POOL_SIZE(POOL_SIZE)
    ) tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_strobe     (o_strobe),
        .i_res        (o_res),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding),
        .o_fresh      (n_fresh),
        .o_reclaim    (n_reclaim),
        .o_freed      (n_freed),
        .o_ignored    (n_ignored)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t ns  timeout with %0d results outstanding", $realtime, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(input logic act, input logic [3:0] h, input logic inv);
        t_cmd c;
        c.action         = act;
        c.handle         = h;
        c.handle_invalid = inv;
        return c;
    endfunction

    task automatic issue(input t_cmd c);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sent++;
        @(negedge i_clk);
    endtask

    // hold commands off until every answer is back
    task automatic drain();
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    initial begin
        t_cmd c;
        int   get_pct;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(make_cmd(ACT_RELEASE, 4'd0, 1'b0));
        issue(make_cmd(ACT_RELEASE, 4'd3, 1'b1));
        for (int i = 0; i < POOL_SIZE; i++)
            issue(make_cmd(ACT_GET, 4'(15 - i), 1'(i)));
        issue(make_cmd(ACT_GET, 4'd15, 1'b1));
        issue(make_cmd(ACT_RELEASE, 4'd5, 1'b1));
        issue(make_cmd(ACT_RELEASE, 4'd5, 1'b0));
        issue(make_cmd(ACT_RELEASE, 4'd1, 1'b0));
        issue(make_cmd(ACT_RELEASE, 4'd0, 1'b0));
        issue(make_cmd(ACT_RELEASE, 4'd5, 1'b0));
        issue(make_cmd(ACT_GET, 4'd0, 1'b0));
        issue(make_cmd(ACT_RELEASE, 4'd15, 1'b0));
        drain();

        get_pct = 50;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       idle_pct = 28;
                1:       idle_pct = 80;
                default: idle_pct = 0;
            endcase
            if (phase == 2) drain();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % CHUNK_ITEMS == 0) begin
                    case ($urandom_range(2))
                        0:       get_pct = 15;
                        1:       get_pct = 50;
                        default: get_pct = 85;
                    endcase
                end
                c.action         = ($urandom_range(99) < get_pct) ? ACT_GET : ACT_RELEASE;
                c.handle         = 4'($urandom_range(15));
                c.handle_invalid = ($urandom_range(7) == 0);
                issue(c);
            end
        end
        drain();

        $display("covered %0d commands in %0d cycles", sent, cycles);
        $display("grants from free FIFO %0d, reclaims %0d, releases %0d, ignored releases %0d",
                 n_fresh, n_reclaim, n_freed, n_ignored);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- handle_pool_oldest_reuse_unit.f -----
src/hpor_pkg.sv
src/hpor_free_queue.sv
src/hpor_link_table.sv
src/handle_pool_oldest_reuse_unit.sv
tb/handle_pool_tracker.sv
tb/tb_handle_pool_oldest_reuse_unit.sv
